@@ rtl/bmi_pkg.sv @@
// bmi_pkg: shared constants, codes and control structs for the bezier motion interpolator
// no dependencies

package bmi_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int PROG_FRAC_DEF  = 16;

    localparam int OUT_W     = 21;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam int DUR_W     = 24;
    localparam int ELAPSED_W = 20;
    localparam int ACTION_W  = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_POINT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_POINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_POINT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION = 2'd3;

    // progress operations
    localparam logic [1:0] PROG_HOLD  = 2'd0;
    localparam logic [1:0] PROG_CLEAR = 2'd1;
    localparam logic [1:0] PROG_FULL  = 2'd2;
    localparam logic [1:0] PROG_ADD   = 2'd3;

    // multiplier operations
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_QQ   = 3'd1;
    localparam logic [2:0] MUL_EE   = 3'd2;
    localparam logic [2:0] MUL_UE   = 3'd3;
    localparam logic [2:0] MUL_T0   = 3'd4;
    localparam logic [2:0] MUL_T1   = 3'd5;
    localparam logic [2:0] MUL_T2   = 3'd6;

    // result position source
    localparam logic [1:0] POS_ZERO   = 2'd0;
    localparam logic [1:0] POS_TARGET = 2'd1;
    localparam logic [1:0] POS_CURVE  = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       div_init;
        logic       div_step;
        logic [1:0] prog_op;
        logic [2:0] mul_op;
        logic [1:0] coord_idx;
        logic       res_load;
        logic [1:0] pos_sel;
        logic       res_valid;
        logic       res_still;
        logic       res_done;
    } bmi_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                dur_reached;
        logic                prog_sat;
        logic                out_free;
    } bmi_status_t;

endpackage

@@ rtl/bmi_if.sv @@
// bmi_item_if, bmi_result_if: valid/ready channels for items and results
// depends on bmi_pkg

interface bmi_item_if;
    logic                         valid;
    logic                         ready;
    logic [bmi_pkg::ACTION_W-1:0]  action;
    logic [bmi_pkg::ELAPSED_W-1:0] elapsed_time;

    modport source (output valid, output action, output elapsed_time, input ready);
    modport sink   (input valid, input action, input elapsed_time, output ready);
endinterface

interface bmi_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [bmi_pkg::OUT_W-1:0] position_x;
    logic signed [bmi_pkg::OUT_W-1:0] position_y;
    logic signed [bmi_pkg::OUT_W-1:0] position_z;
    logic                             position_valid;
    logic                             still_moving;
    logic                             move_done;

    modport source (output valid, output position_x, output position_y, output position_z,
                    output position_valid, output still_moving, output move_done,
                    input ready);
    modport sink   (input valid, input position_x, input position_y, input position_z,
                    input position_valid, input still_moving, input move_done,
                    output ready);
endinterface

@@ rtl/bmi_ctrl.sv @@
// bmi_ctrl: sequencer for one item at a time, owns the moving flag
// depends on bmi_pkg; drives bmi_dp through bmi_cmd_t

module bmi_ctrl #(
    parameter int PROGRESS_FRAC_BITS = bmi_pkg::PROG_FRAC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  bmi_pkg::bmi_status_t status,
    output bmi_pkg::bmi_cmd_t    cmd
);

    localparam int F  = PROGRESS_FRAC_BITS;
    localparam int CW = $clog2(F);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_PROG   = 4'd3;
    localparam logic [3:0] ST_MQQ    = 4'd4;
    localparam logic [3:0] ST_MWAIT  = 4'd5;
    localparam logic [3:0] ST_MEE    = 4'd6;
    localparam logic [3:0] ST_MUE    = 4'd7;
    localparam logic [3:0] ST_MW     = 4'd8;
    localparam logic [3:0] ST_COORD  = 4'd9;
    localparam logic [3:0] ST_MLAST  = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic          moving_reg, moving_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    k_reg, k_next;
    logic [1:0]    j_reg, j_next;
    logic [1:0]    pos_reg, pos_next;
    logic          rvalid_reg, rvalid_next;
    logic          rstill_reg, rstill_next;
    logic          rdone_reg, rdone_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            moving_reg <= 1'b0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            j_reg      <= '0;
            pos_reg    <= bmi_pkg::POS_ZERO;
            rvalid_reg <= 1'b0;
            rstill_reg <= 1'b0;
            rdone_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            moving_reg <= moving_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            pos_reg    <= pos_next;
            rvalid_reg <= rvalid_next;
            rstill_reg <= rstill_next;
            rdone_reg  <= rdone_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        moving_next = moving_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        rvalid_next = rvalid_reg;
        rstill_next = rstill_reg;
        rdone_next  = rdone_reg;
        cmd         = '0;
        cmd.prog_op = bmi_pkg::PROG_HOLD;
        cmd.mul_op  = bmi_pkg::MUL_NONE;
        cmd.pos_sel = bmi_pkg::POS_ZERO;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                pos_next    = bmi_pkg::POS_ZERO;
                rvalid_next = 1'b0;
                rstill_next = 1'b0;
                rdone_next  = 1'b0;
                state_next  = ST_DONE;
                unique case (status.action)
                    bmi_pkg::ACT_START:
                    begin
                        moving_next = 1'b1;
                        cmd.prog_op = bmi_pkg::PROG_CLEAR;
                        rstill_next = 1'b1;
                    end
                    bmi_pkg::ACT_CANCEL:
                    begin
                        moving_next = 1'b0;
                        cmd.prog_op = bmi_pkg::PROG_CLEAR;
                    end
                    bmi_pkg::ACT_NOP:
                    begin
                        rstill_next = moving_reg;
                    end
                    default:
                    begin
                        if (moving_reg && status.dur_reached)
                        begin
                            // whole duration covered, or zero duration: snap
                            moving_next = 1'b0;
                            cmd.prog_op = bmi_pkg::PROG_FULL;
                            pos_next    = bmi_pkg::POS_TARGET;
                            rvalid_next = 1'b1;
                            rdone_next  = 1'b1;
                        end
                        else if (moving_reg)
                        begin
                            cmd.div_init = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(F - 1))
                begin
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                cmd.prog_op = bmi_pkg::PROG_ADD;
                if (status.prog_sat)
                begin
                    moving_next = 1'b0;
                    pos_next    = bmi_pkg::POS_TARGET;
                    rvalid_next = 1'b1;
                    rstill_next = 1'b0;
                    rdone_next  = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    pos_next    = bmi_pkg::POS_CURVE;
                    rvalid_next = 1'b1;
                    rstill_next = 1'b1;
                    rdone_next  = 1'b0;
                    state_next  = ST_MQQ;
                end
            end
            ST_MQQ:
            begin
                cmd.mul_op = bmi_pkg::MUL_QQ;
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                state_next = ST_MEE;
            end
            ST_MEE:
            begin
                cmd.mul_op = bmi_pkg::MUL_EE;
                state_next = ST_MUE;
            end
            ST_MUE:
            begin
                cmd.mul_op = bmi_pkg::MUL_UE;
                state_next = ST_MW;
            end
            ST_MW:
            begin
                k_next     = '0;
                j_next     = '0;
                state_next = ST_COORD;
            end
            ST_COORD:
            begin
                cmd.coord_idx = k_reg;
                case (j_reg)
                    2'd0:    cmd.mul_op = bmi_pkg::MUL_T0;
                    2'd1:    cmd.mul_op = bmi_pkg::MUL_T1;
                    default: cmd.mul_op = bmi_pkg::MUL_T2;
                endcase
                if (j_reg == 2'd2)
                begin
                    j_next = '0;
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_MLAST;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MLAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.pos_sel   = pos_reg;
                    cmd.res_valid = rvalid_reg;
                    cmd.res_still = rstill_reg;
                    cmd.res_done  = rdone_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bmi_dp.sv @@
// bmi_dp: config registers, restoring divider, shared multiplier, progress and result register
// depends on bmi_pkg; commanded by bmi_ctrl

module bmi_dp #(
    parameter int COORD_BITS         = bmi_pkg::COORD_BITS_DEF,
    parameter int PROGRESS_FRAC_BITS = bmi_pkg::PROG_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmi_pkg::CFG_W-1:0]         cfg_data,
    input  logic [bmi_pkg::ACTION_W-1:0]      in_action,
    input  logic [bmi_pkg::ELAPSED_W-1:0]     in_elapsed,
    input  logic                              out_ready,
    input  bmi_pkg::bmi_cmd_t                 cmd,
    output bmi_pkg::bmi_status_t              status,
    output logic                              out_valid,
    output logic signed [bmi_pkg::OUT_W-1:0]  out_x,
    output logic signed [bmi_pkg::OUT_W-1:0]  out_y,
    output logic signed [bmi_pkg::OUT_W-1:0]  out_z,
    output logic                              out_pos_valid,
    output logic                              out_still,
    output logic                              out_done
);

    localparam int CB  = COORD_BITS;
    localparam int F   = PROGRESS_FRAC_BITS;
    localparam int PW  = F + 1;
    localparam int MW  = (F + 2 > CB) ? F + 2 : CB;
    localparam int PRW = 2 * MW;
    localparam int DW  = bmi_pkg::DUR_W;
    localparam int EW  = bmi_pkg::ELAPSED_W;
    localparam int GW  = bmi_pkg::CFG_W;
    localparam int OW  = bmi_pkg::OUT_W;

    localparam logic [PW-1:0]         ONE  = {1'b1, {F{1'b0}}};
    localparam logic signed [PRW-1:0] HALF = PRW'(1) << (F - 1);

    function automatic logic signed [CB-1:0] coord_of(input logic [GW-1:0] r,
                                                      input logic [1:0] k);
        logic signed [CB-1:0] c;
        case (k)
            2'd0:    c = r[3*CB-1 -: CB];
            2'd1:    c = r[2*CB-1 -: CB];
            default: c = r[CB-1:0];
        endcase
        return c;
    endfunction

    logic [GW-1:0]          start_reg, control_reg, target_reg;
    logic [DW-1:0]          dur_reg;
    logic [bmi_pkg::ACTION_W-1:0] action_reg;
    logic [EW-1:0]          elapsed_reg;
    logic [DW-1:0]          rem_reg;
    logic [F-1:0]           quo_reg;
    logic [PW-1:0]          prog_reg;
    logic [PW-1:0]          e_reg, w0_reg, w1_reg, w2_reg;
    logic signed [PRW-1:0]  prod_reg, acc_reg;
    logic [2:0]             tag_reg;
    logic [1:0]             tag_idx_reg;
    logic signed [CB-1:0]   px_reg, py_reg, pz_reg;
    logic                   out_valid_reg, out_valid_next;
    logic signed [OW-1:0]   ox_reg, oy_reg, oz_reg;
    logic                   opv_reg, ost_reg, odn_reg;

    logic [DW:0]            rem_sh;
    logic                   rem_ge;
    logic [PW:0]            prog_sum;
    logic                   prog_sat;
    logic [PW-1:0]          q_val, u_val, w1_val;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PRW-1:0]  acc_sum;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            control_reg <= '0;
            target_reg  <= '0;
            dur_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmi_pkg::REG_START_POINT:   start_reg   <= cfg_data;
                bmi_pkg::REG_CONTROL_POINT: control_reg <= cfg_data;
                bmi_pkg::REG_TARGET_POINT:  target_reg  <= cfg_data;
                bmi_pkg::REG_MOVE_DURATION: dur_reg     <= cfg_data[DW-1:0];
                default:                    dur_reg     <= dur_reg;
            endcase
        end
    end

    // input capture and divider
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, dur_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg  <= in_action;
            elapsed_reg <= in_elapsed;
        end
        if (cmd.div_init)
        begin
            rem_reg <= {{(DW-EW){1'b0}}, elapsed_reg};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? DW'(rem_sh - {1'b0, dur_reg}) : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[F-2:0], rem_ge};
        end
    end

    // progress
    assign prog_sum = {1'b0, prog_reg} + {2'b00, quo_reg};
    assign prog_sat = (prog_sum >= {1'b0, ONE});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= '0;
        end
        else
        begin
            case (cmd.prog_op)
                bmi_pkg::PROG_CLEAR: prog_reg <= '0;
                bmi_pkg::PROG_FULL:  prog_reg <= ONE;
                bmi_pkg::PROG_ADD:   prog_reg <= prog_sat ? ONE : prog_sum[PW-1:0];
                default:             prog_reg <= prog_reg;
            endcase
        end
    end

    // shared multiplier
    assign q_val = ONE - prog_reg;
    assign u_val = ONE - e_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            bmi_pkg::MUL_QQ:
            begin
                mul_a = MW'(q_val);
                mul_b = MW'(q_val);
            end
            bmi_pkg::MUL_EE:
            begin
                mul_a = MW'(e_reg);
                mul_b = MW'(e_reg);
            end
            bmi_pkg::MUL_UE:
            begin
                mul_a = MW'(u_val);
                mul_b = MW'(e_reg);
            end
            bmi_pkg::MUL_T0:
            begin
                mul_a = MW'(w0_reg);
                mul_b = MW'(coord_of(start_reg, cmd.coord_idx));
            end
            bmi_pkg::MUL_T1:
            begin
                mul_a = MW'(w1_reg);
                mul_b = MW'(coord_of(control_reg, cmd.coord_idx));
            end
            bmi_pkg::MUL_T2:
            begin
                mul_a = MW'(w2_reg);
                mul_b = MW'(coord_of(target_reg, cmd.coord_idx));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= bmi_pkg::MUL_NONE;
        end
        else
        begin
            tag_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        tag_idx_reg <= cmd.coord_idx;
    end

    // product consumers
    assign w1_val  = prod_reg[F-1 +: PW];
    assign acc_sum = acc_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        case (tag_reg)
            bmi_pkg::MUL_QQ: e_reg <= ONE - prod_reg[F +: PW];
            bmi_pkg::MUL_EE: w2_reg <= prod_reg[F +: PW];
            bmi_pkg::MUL_UE:
            begin
                w1_reg <= w1_val;
                w0_reg <= ONE - w1_val - w2_reg;
            end
            bmi_pkg::MUL_T0: acc_reg <= prod_reg + HALF;
            bmi_pkg::MUL_T1: acc_reg <= acc_sum;
            bmi_pkg::MUL_T2:
            begin
                case (tag_idx_reg)
                    2'd0:    px_reg <= acc_sum[F +: CB];
                    2'd1:    py_reg <= acc_sum[F +: CB];
                    default: pz_reg <= acc_sum[F +: CB];
                endcase
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // result register
    assign out_valid_next = cmd.res_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            opv_reg <= cmd.res_valid;
            ost_reg <= cmd.res_still;
            odn_reg <= cmd.res_done;
            case (cmd.pos_sel)
                bmi_pkg::POS_TARGET:
                begin
                    ox_reg <= OW'(coord_of(target_reg, 2'd0));
                    oy_reg <= OW'(coord_of(target_reg, 2'd1));
                    oz_reg <= OW'(coord_of(target_reg, 2'd2));
                end
                bmi_pkg::POS_CURVE:
                begin
                    ox_reg <= OW'(px_reg);
                    oy_reg <= OW'(py_reg);
                    oz_reg <= OW'(pz_reg);
                end
                default:
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                    oz_reg <= '0;
                end
            endcase
        end
    end

    assign status.action      = action_reg;
    assign status.dur_reached = ({{(DW-EW){1'b0}}, elapsed_reg} >= dur_reg);
    assign status.prog_sat    = prog_sat;
    assign status.out_free    = ~out_valid_reg | out_ready;

    assign out_valid     = out_valid_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_z         = oz_reg;
    assign out_pos_valid = opv_reg;
    assign out_still     = ost_reg;
    assign out_done      = odn_reg;

endmodule

@@ rtl/bezier_motion_interpolator.sv @@
// bezier_motion_interpolator: top level, joins bmi_ctrl and bmi_dp to the channels
// depends on bmi_pkg, bmi_if, bmi_ctrl, bmi_dp
// start, cancel, unused code, idle tick and snapping tick pass IDLE, DECIDE and DONE;
//   a tick mid-move runs the divider in DIV (one divider bit per cycle), then PROG and
//   12 passes through the shared multiplier; DONE waits until the result slot is free
// one item at a time: the next input is accepted only once DONE has loaded the result
// reset: asynchronous, clears moving, progress and all configuration registers to zero

module bezier_motion_interpolator #(
    parameter int COORD_BITS         = bmi_pkg::COORD_BITS_DEF,
    parameter int PROGRESS_FRAC_BITS = bmi_pkg::PROG_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bmi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmi_pkg::CFG_W-1:0]     cfg_data,
    bmi_item_if.sink                      item,
    bmi_result_if.source                  result
);

    bmi_pkg::bmi_cmd_t    cmd;
    bmi_pkg::bmi_status_t status;

    bmi_ctrl #(
        .PROGRESS_FRAC_BITS (PROGRESS_FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    bmi_dp #(
        .COORD_BITS         (COORD_BITS),
        .PROGRESS_FRAC_BITS (PROGRESS_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_action     (item.action),
        .in_elapsed    (item.elapsed_time),
        .out_ready     (result.ready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (result.valid),
        .out_x         (result.position_x),
        .out_y         (result.position_y),
        .out_z         (result.position_z),
        .out_pos_valid (result.position_valid),
        .out_still     (result.still_moving),
        .out_done      (result.move_done)
    );

endmodule

@@ rtl/bmi_checker.sv @@
// bmi_checker: port-level assertions for bezier_motion_interpolator, with its bind
// depends on bmi_pkg; attached to the top level by bind

module bmi_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic signed [bmi_pkg::OUT_W-1:0] position_x,
    input logic signed [bmi_pkg::OUT_W-1:0] position_y,
    input logic signed [bmi_pkg::OUT_W-1:0] position_z,
    input logic                             position_valid,
    input logic                             still_moving,
    input logic                             move_done
);

    // pending result holds until transfer
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input accepted while busy");

    a_zero_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !position_valid |->
            position_x == '0 && position_y == '0 && position_z == '0)
        else $error("position set without position_valid");

    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && move_done |-> position_valid && !still_moving)
        else $error("move_done with inconsistent flags");

endmodule

bind bezier_motion_interpolator bmi_checker u_bmi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .position_x     (result.position_x),
    .position_y     (result.position_y),
    .position_z     (result.position_z),
    .position_valid (result.position_valid),
    .still_moving   (result.still_moving),
    .move_done      (result.move_done)
);
